FILE: sv/priority_ready_queue_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ready queue scheduler
// Same-cycle and next-cycle implication checks, reset disables both.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PRQS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Consequent must hold in the cycle after the antecedent
`define PRQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

FILE: sv/prqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared widths, operation codes and cell control types of the scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

   localparam int ID_W            = 5;
   localparam int PRI_W           = 8;
   localparam int OP_W            = 3;
   localparam int DEF_MAX_THREADS = 32;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_MAKE_READY = 3'd0,
      OP_DISPATCH   = 3'd1,
      OP_YIELD      = 3'd2,
      OP_BLOCK      = 3'd3,
      OP_FINISH     = 3'd4
   } op_type;

   // what every cell of the queue does in one cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2
   } cell_op_type;

   // broadcast to all cells
   typedef struct packed {
      cell_op_type        op;
      logic [ID_W-1:0]    id;
      logic [PRI_W-1:0]   pri;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: sv/prqs_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prqs request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface prqs_req_if
   import prqs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ID_W-1:0]   tid_req;
   logic [PRI_W-1:0]  priority_req;

   modport source (output valid, output operation, output tid_req,
                   output priority_req, input ready);
   modport sink   (input valid, input operation, input tid_req,
                   input priority_req, output ready);
endinterface

interface prqs_rsp_if
   import prqs_pkg::*;
   #(parameter int CNT_W = $clog2(DEF_MAX_THREADS + 1))
   ();
   logic              valid;
   logic              ready;
   logic              running_valid;
   logic [ID_W-1:0]   running_id;
   logic [CNT_W-1:0]  ready_count;
   logic              went_idle;
   logic              dropped;

   modport source (output valid, output running_valid, output running_id,
                   output ready_count, output went_idle, output dropped,
                   input ready);
   modport sink   (input valid, input running_valid, input running_id,
                   input ready_count, input went_idle, input dropped,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/prqs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prqs_cell
// One slot of the ordered ready queue. Holds an entry and trades it with
// its neighbors on insert (shift toward tail) and pop (shift toward head).
// ----------------------------------------------------------------------------
module prqs_cell
   import prqs_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic              occupied,
   input  wire logic              left_keep,
   input  wire logic [ID_W-1:0]   left_id,
   input  wire logic [PRI_W-1:0]  left_pri,
   input  wire logic [ID_W-1:0]   right_id,
   input  wire logic [PRI_W-1:0]  right_pri,
   output logic                   keep,
   output logic [ID_W-1:0]        id,
   output logic [PRI_W-1:0]       pri
);

   logic [ID_W-1:0]  id_ff,  id_in;
   logic [PRI_W-1:0] pri_ff, pri_in;

   // entry stays put when it ranks at or above the newcomer
   assign keep = occupied && (pri_ff >= ctl.pri);

   always_comb begin
      id_in  = id_ff;
      pri_in = pri_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  // first slot past the kept run takes the newcomer
                  id_in  = ctl.id;
                  pri_in = ctl.pri;
               end else begin
                  id_in  = left_id;
                  pri_in = left_pri;
               end
            end
         end
         CELL_POP: begin
            id_in  = right_id;
            pri_in = right_pri;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

   assign id  = id_ff;
   assign pri = pri_ff;

endmodule

`default_nettype wire

FILE: sv/priority_ready_queue_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Thread scheduler: priority-ordered ready queue plus one running thread.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries one scheduler operation per beat (make ready, dispatch,
//  yield, block, finish) with a thread id and priority for make ready.
//  rsp_bus returns one beat per request: the running thread, queue depth
//  and the went_idle / dropped flags.
//  A request is latched in the cycle it is accepted and executed once the
//  response register is empty or draining, when the queue cells insert or
//  pop in parallel and the response register loads. The command register
//  holds one operation until the cell row has executed it, and no new
//  request is taken until then.
//  Reset empties the queue (count to zero) and leaves the CPU idle; no
//  clearing pass is needed since slots past the count are never read.
//  If the receiver stalls, the response register holds its beat; one more
//  request may be accepted and waits in the command register, after which
//  req_bus.ready stays low until the response drains.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
   import prqs_pkg::*;
#(
   parameter int MAX_THREADS = DEF_MAX_THREADS
)(
   input  wire logic     clock,
   input  wire logic     reset,
   prqs_req_if.sink      req_bus,
   prqs_rsp_if.source    rsp_bus
);

   `include "priority_ready_queue_scheduler_assert.svh"

   localparam int CNT_W = $clog2(MAX_THREADS + 1);

   // command register
   logic              pend_ff, pend_in;
   logic [OP_W-1:0]   cmd_op_ff;
   logic [ID_W-1:0]   cmd_id_ff;
   logic [PRI_W-1:0]  cmd_pri_ff;

   // scheduler state
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              busy_ff, busy_in;
   logic [ID_W-1:0]   cur_id_ff, cur_id_in;
   logic [PRI_W-1:0]  cur_pri_ff, cur_pri_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              idle_ff, idle_in;
   logic              drop_ff, drop_in;

   logic              req_take, exec, full, empty;
   cell_ctl_type      ctl;

   // cell row wiring
   logic [MAX_THREADS-1:0] cell_keep;
   logic [ID_W-1:0]        cell_id  [MAX_THREADS];
   logic [PRI_W-1:0]       cell_pri [MAX_THREADS];

   assign req_bus.ready = !pend_ff;
   assign req_take      = req_bus.valid && !pend_ff;
   assign exec          = pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign full          = (len_ff == CNT_W'(MAX_THREADS));
   assign empty         = (len_ff == '0);

   // operation decode
   always_comb begin
      ctl        = '{op: CELL_HOLD, id: cmd_id_ff, pri: cmd_pri_ff};
      len_in     = len_ff;
      busy_in    = busy_ff;
      cur_id_in  = cur_id_ff;
      cur_pri_in = cur_pri_ff;
      idle_in    = idle_ff;
      drop_in    = drop_ff;
      if (exec) begin
         idle_in = 1'b0;
         drop_in = 1'b0;
         unique case (cmd_op_ff)
            OP_MAKE_READY: begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  ctl.op = CELL_INSERT;
                  len_in = len_ff + 1'b1;
               end
            end
            OP_DISPATCH: begin
               if (!busy_ff) begin
                  if (empty) begin
                     idle_in = 1'b1;
                  end else begin
                     ctl.op     = CELL_POP;
                     len_in     = len_ff - 1'b1;
                     busy_in    = 1'b1;
                     cur_id_in  = cell_id[0];
                     cur_pri_in = cell_pri[0];
                  end
               end
            end
            OP_YIELD: begin
               if (busy_ff) begin
                  busy_in = 1'b0;
                  ctl.id  = cur_id_ff;
                  ctl.pri = cur_pri_ff;
                  if (full) begin
                     drop_in = 1'b1;
                  end else begin
                     ctl.op = CELL_INSERT;
                     len_in = len_ff + 1'b1;
                  end
               end
            end
            OP_BLOCK, OP_FINISH: begin
               if (empty) begin
                  busy_in = 1'b0;
                  idle_in = 1'b1;
               end else begin
                  ctl.op     = CELL_POP;
                  len_in     = len_ff - 1'b1;
                  busy_in    = 1'b1;
                  cur_id_in  = cell_id[0];
                  cur_pri_in = cell_pri[0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // handshake bookkeeping
   always_comb begin
      pend_in      = (pend_ff && !exec) || req_take;
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         busy_ff      <= 1'b0;
         cur_id_ff    <= '0;
         cur_pri_ff   <= '0;
         idle_ff      <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         busy_ff      <= busy_in;
         cur_id_ff    <= cur_id_in;
         cur_pri_ff   <= cur_pri_in;
         idle_ff      <= idle_in;
         drop_ff      <= drop_in;
      end
   end

   // command payload, loaded on accept
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_op_ff  <= req_bus.operation;
         cmd_id_ff  <= req_bus.tid_req;
         cmd_pri_ff <= req_bus.priority_req;
      end
   end

   // row of queue cells, head at index zero
   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      logic              occ;
      logic              l_keep;
      logic [ID_W-1:0]   l_id, r_id;
      logic [PRI_W-1:0]  l_pri, r_pri;

      assign occ = (len_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         // nothing ranks ahead of the head, so it borders the kept run
         assign l_keep = 1'b1;
         assign l_id   = '0;
         assign l_pri  = '0;
      end else begin : g_body
         assign l_keep = cell_keep[i-1];
         assign l_id   = cell_id[i-1];
         assign l_pri  = cell_pri[i-1];
      end

      if (i == MAX_THREADS - 1) begin : g_tail
         assign r_id  = '0;
         assign r_pri = '0;
      end else begin : g_next
         assign r_id  = cell_id[i+1];
         assign r_pri = cell_pri[i+1];
      end

      prqs_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (occ),
         .left_keep (l_keep),
         .left_id   (l_id),
         .left_pri  (l_pri),
         .right_id  (r_id),
         .right_pri (r_pri),
         .keep      (cell_keep[i]),
         .id        (cell_id[i]),
         .pri       (cell_pri[i])
      );
   end

   // response outputs
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.running_valid = busy_ff;
   assign rsp_bus.running_id    = busy_ff ? cur_id_ff : '0;
   assign rsp_bus.ready_count   = len_ff;
   assign rsp_bus.went_idle     = idle_ff;
   assign rsp_bus.dropped       = drop_ff;

   // checks
   `PRQS_ASSERT_NOW(a_drop_only_full, clock, reset, rsp_valid_ff && drop_ff,
                    len_ff == CNT_W'(MAX_THREADS))
   `PRQS_ASSERT_NOW(a_idle_means_empty, clock, reset, rsp_valid_ff && idle_ff,
                    !busy_ff && len_ff == '0)
   `PRQS_ASSERT_NEXT(a_accept_blocks, clock, reset, req_take,
                     pend_ff && !req_bus.ready)

endmodule

`default_nettype wire
